FILE: design/psrt_pkg.sv
package psrt_pkg;

  localparam int DEFAULT_NUM_SESSIONS = 16;

  localparam int TIME_W = 18;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] VALID_LIFETIME_RST = 16'd30000;
  localparam logic [CFG_W-1:0] RETRY_TIMEOUT_RST = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TIMEOUT = 1'b1;

  // request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CREATE = 2'd1;
  localparam logic [1:0] REQ_ADVERT = 2'd2;

  // session status codes
  localparam logic [1:0] ST_WAITING = 2'd0;
  localparam logic [1:0] ST_RENEWING = 2'd1;
  localparam logic [1:0] ST_VALID = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  // reported actions
  localparam logic [3:0] ACT_DONE = 4'd0;
  localparam logic [3:0] ACT_RETRY = 4'd1;
  localparam logic [3:0] ACT_INVALID = 4'd2;
  localparam logic [3:0] ACT_RENEW = 4'd3;
  localparam logic [3:0] ACT_REMOVED = 4'd4;
  localparam logic [3:0] ACT_CREATED = 4'd5;
  localparam logic [3:0] ACT_FULL = 4'd6;
  localparam logic [3:0] ACT_VALID = 4'd7;
  localparam logic [3:0] ACT_UNUSED = 4'd8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  slot;
    logic [15:0] elapsed;
    logic        keep_alive;
    logic [3:0]  retry_limit;
  } req_t;

  typedef struct packed {
    logic [3:0] session_slot;
    logic [3:0] action;
    logic [3:0] fail_count;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [TIME_W-1:0] time_left;
    logic [3:0]               failures;
    logic [3:0]               retries_allowed;
    logic                     renews;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    EM_DONE,
    EM_CREATED,
    EM_FULL,
    EM_UNUSED,
    EM_EXEC
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      idx_inc;
    logic      rd_en;
    logic      wr_create;
    logic      wr_exec;
    logic      emit;
    emit_sel_t emit_sel;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic is_create;
    logic is_advert;
    logic cur_used;
    logic idx_last;
    logic slot_ok;
  } stat_t;

endpackage

FILE: design/psrt_ram.sv
module psrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

FILE: design/psrt_ctrl.sv
module psrt_ctrl
  import psrt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output cmd_t  cmd,
  output logic  busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit_sel = EM_DONE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (st.is_tick) begin
          if (st.cur_used) begin
            cmd.rd_en = 1'b1;
            state_next = S_EXEC;
          end else if (st.idx_last) begin
            state_next = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else if (st.is_create) begin
          if (!st.cur_used) begin
            cmd.wr_create = 1'b1;
            cmd.emit = 1'b1;
            cmd.emit_sel = EM_CREATED;
            state_next = S_IDLE;
          end else if (st.idx_last) begin
            cmd.emit = 1'b1;
            cmd.emit_sel = EM_FULL;
            state_next = S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end else if (st.is_advert) begin
          if (st.slot_ok && st.cur_used) begin
            cmd.rd_en = 1'b1;
            state_next = S_EXEC;
          end else begin
            cmd.emit = 1'b1;
            cmd.emit_sel = EM_UNUSED;
            state_next = S_IDLE;
          end
        end else begin
          cmd.emit = 1'b1;
          cmd.emit_sel = EM_DONE;
          state_next = S_IDLE;
        end
      end
      S_EXEC: begin
        cmd.wr_exec = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_EXEC;
        if (st.is_tick) begin
          if (st.idx_last) begin
            state_next = S_FIN;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next = S_SCAN;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FIN: begin
        cmd.emit = 1'b1;
        cmd.emit_sel = EM_DONE;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/psrt_dp.sv
module psrt_dp
  import psrt_pkg::*;
#(
  parameter int NUM_SESSIONS = DEFAULT_NUM_SESSIONS,
  localparam int IDX_W = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output stat_t                st,
  output logic                 result_valid,
  output result_t              result
);

  logic [CFG_W-1:0] valid_lifetime;
  logic [CFG_W-1:0] retry_timeout;

  req_t                    req_q;
  logic [IDX_W-1:0]        idx;
  logic [NUM_SESSIONS-1:0] in_use;

  rec_t rd_rec;
  rec_t wr_rec;
  rec_t exec_rec;
  logic exec_report;
  logic exec_remove;
  logic [3:0] exec_action;
  logic [3:0] exec_fc;

  logic signed [TIME_W:0]   diff;
  logic signed [TIME_W-1:0] t_sat;
  logic [TIME_W-1:0]        retry_time;
  logic [TIME_W-1:0]        valid_time;

  logic    result_valid_next;
  result_t result_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_lifetime <= VALID_LIFETIME_RST;
      retry_timeout <= RETRY_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VALID_LIFETIME: valid_lifetime <= cfg_data;
        CFG_RETRY_TIMEOUT:  retry_timeout <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= (req.req_type == REQ_ADVERT) ? IDX_W'(32'(req.slot)) : '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (cmd.wr_create) begin
      in_use[idx] <= 1'b1;
    end else if (cmd.wr_exec && exec_remove) begin
      in_use[idx] <= 1'b0;
    end
  end

  assign st.is_tick   = (req_q.req_type == REQ_TICK);
  assign st.is_create = (req_q.req_type == REQ_CREATE);
  assign st.is_advert = (req_q.req_type == REQ_ADVERT);
  assign st.cur_used  = in_use[idx];
  assign st.idx_last  = (idx == IDX_W'(NUM_SESSIONS - 1));
  assign st.slot_ok   = (32'(req_q.slot) < NUM_SESSIONS);

  psrt_ram #(
    .WIDTH(REC_W),
    .DEPTH(NUM_SESSIONS)
  ) u_rec_ram (
    .clk  (clk),
    .we   (cmd.wr_create | cmd.wr_exec),
    .re   (cmd.rd_en),
    .addr (idx),
    .wdata(wr_rec),
    .rdata(rd_rec)
  );

  assign retry_time = {{(TIME_W-CFG_W){1'b0}}, retry_timeout};
  assign valid_time = {{(TIME_W-CFG_W){1'b0}}, valid_lifetime};

  // lifetime after the tick, saturating at the low bound
  assign diff  = {rd_rec.time_left[TIME_W-1], rd_rec.time_left}
               - {{(TIME_W+1-16){1'b0}}, req_q.elapsed};
  assign t_sat = (diff[TIME_W] && !diff[TIME_W-1]) ? {1'b1, {(TIME_W-1){1'b0}}}
                                                   : diff[TIME_W-1:0];

  always_comb begin
    exec_rec = rd_rec;
    exec_report = 1'b0;
    exec_remove = 1'b0;
    exec_action = ACT_DONE;
    exec_fc = 4'd0;
    if (!st.is_tick) begin
      // advert to a live slot
      exec_rec.status = ST_VALID;
      exec_rec.time_left = valid_time;
      exec_rec.failures = 4'd0;
      exec_report = 1'b1;
      exec_action = ACT_VALID;
    end else begin
      exec_rec.time_left = t_sat;
      if (t_sat[TIME_W-1]) begin
        unique case (rd_rec.status)
          ST_WAITING, ST_RENEWING: begin
            exec_rec.time_left = retry_time;
            exec_report = 1'b1;
            if (rd_rec.failures < rd_rec.retries_allowed) begin
              exec_rec.failures = rd_rec.failures + 4'd1;
              exec_action = ACT_RETRY;
              exec_fc = rd_rec.failures + 4'd1;
            end else begin
              exec_rec.status = ST_INVALID;
              exec_action = ACT_INVALID;
              exec_fc = rd_rec.failures;
            end
          end
          ST_VALID: begin
            if (rd_rec.renews) begin
              exec_rec.status = ST_RENEWING;
              exec_rec.time_left = retry_time;
              exec_rec.failures = 4'd0;
              exec_report = 1'b1;
              exec_action = ACT_RENEW;
            end
          end
          ST_INVALID: begin
            exec_remove = 1'b1;
            exec_report = 1'b1;
            exec_action = ACT_REMOVED;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (cmd.wr_create) begin
      wr_rec.status = ST_WAITING;
      wr_rec.time_left = valid_time;
      wr_rec.failures = 4'd0;
      wr_rec.retries_allowed = req_q.retry_limit;
      wr_rec.renews = req_q.keep_alive;
    end else begin
      wr_rec = exec_rec;
    end
  end

  always_comb begin
    result_next = '0;
    result_next.last = 1'b1;
    result_valid_next = cmd.emit;
    unique case (cmd.emit_sel)
      EM_DONE: begin
      end
      EM_CREATED: begin
        result_next.session_slot = 4'(32'(idx));
        result_next.action = ACT_CREATED;
      end
      EM_FULL: begin
        result_next.action = ACT_FULL;
      end
      EM_UNUSED: begin
        result_next.session_slot = req_q.slot;
        result_next.action = ACT_UNUSED;
      end
      EM_EXEC: begin
        result_valid_next = cmd.emit && exec_report;
        result_next.session_slot = 4'(32'(idx));
        result_next.action = exec_action;
        result_next.fail_count = exec_fc;
        result_next.last = !st.is_tick;
      end
      default: begin
        result_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

FILE: design/proxy_session_retry_table.sv
// Session retry table. A request is taken when start is high and busy is low;
// results come back on result with a one-cycle result_valid strobe, one cycle
// after the work that makes them, and the receiver cannot stall them, so it
// must take every strobe as it comes. The final result of each request has
// last set. A tick walks every slot from 0 upward through the single-port
// session RAM: a free slot is passed over, a live one is read, then updated
// and written back; the request is loaded first and a closing result ends
// the walk. A create scans the in-use bits for the lowest free slot; an
// advert to a live slot is loaded, read from the RAM and updated; an advert
// to a free or out-of-range slot and any other request are answered straight
// after the load. The scan counter and the one RAM port set this pacing. busy
// stays high until the last result has been produced, and a new request may
// be issued in the cycle that last result is shown.
// Configuration registers are written through cfg_we/cfg_index/cfg_data while
// the block is idle; the user must keep to this, as the block itself does not
// enforce it. No reset pass over the RAM is needed, as a slot is read only
// after its in-use bit shows it was written by a create.
module proxy_session_retry_table_core
  import psrt_pkg::*;
#(
  parameter int NUM_SESSIONS = DEFAULT_NUM_SESSIONS
) (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // result strobe
  output logic                 result_valid,
  output result_t              result
);

  cmd_t  cmd;
  stat_t st;

  // sequencer: decides per cycle what the datapath does
  psrt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .st   (st),
    .cmd  (cmd),
    .busy (busy)
  );

  // session store, slot counter, per-slot update and result register
  psrt_dp #(
    .NUM_SESSIONS(NUM_SESSIONS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .st          (st),
    .result_valid(result_valid),
    .result      (result)
  );

`ifndef SYNTHESIS
  // an accepted request always puts the sequencer to work
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // the end of a request always shows its closing result
  a_fall_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && result.last)
    else $error("request finished without a final result");

  // intermediate tick results only appear while the walk goes on
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> busy)
    else $error("non-final result after the request ended");
`endif

endmodule

FILE: sim/proxy_session_retry_table_core_tb.sv
`timescale 1ns / 100ps

import psrt_pkg::*;

// shadow of the session table plus the queue of results it predicts
class session_table_tracker;
  localparam int SLOTS = DEFAULT_NUM_SESSIONS;
  localparam int TIME_FLOOR = -(1 << (TIME_W - 1));

  bit          in_use[SLOTS];
  logic [1:0]  status[SLOTS];
  int          time_left[SLOTS];
  logic [3:0]  failures[SLOTS];
  logic [3:0]  retries_allowed[SLOTS];
  bit          renews[SLOTS];
  logic [15:0] lifetime_reg;
  logic [15:0] retry_reg;
  result_t     awaited[$];
  int          errors;
  int          requests_seen;
  int          results_seen;
  int          saturations;
  int          action_count[16];

  function void clear();
    lifetime_reg = VALID_LIFETIME_RST;
    retry_reg = RETRY_TIMEOUT_RST;
    foreach (in_use[i]) in_use[i] = 1'b0;
    foreach (action_count[i]) action_count[i] = 0;
    awaited.delete();
    errors = 0;
    requests_seen = 0;
    results_seen = 0;
    saturations = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    if (idx == CFG_VALID_LIFETIME) begin
      lifetime_reg = value;
    end else if (idx == CFG_RETRY_TIMEOUT) begin
      retry_reg = value;
    end
  endfunction

  function void push(logic [3:0] s, logic [3:0] act, logic [3:0] fc, logic lst);
    result_t r;
    r.session_slot = s;
    r.action = act;
    r.fail_count = fc;
    r.last = lst;
    awaited.insert(awaited.size(), r);
  endfunction

  function int awaited_count();
    return awaited.size();
  endfunction

  function void note_request(req_t r);
    int  t;
    bit  placed;
    requests_seen++;
    case (r.req_type)
      REQ_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use[i]) begin
            t = time_left[i] - int'(r.elapsed);
            if (t < TIME_FLOOR) begin
              t = TIME_FLOOR;
              saturations++;
            end
            time_left[i] = t;
            if (t < 0) begin
              case (status[i])
                ST_WAITING, ST_RENEWING: begin
                  time_left[i] = int'(retry_reg);
                  if (failures[i] < retries_allowed[i]) begin
                    failures[i] = failures[i] + 4'd1;
                    push(4'(i), ACT_RETRY, failures[i], 1'b0);
                  end else begin
                    status[i] = ST_INVALID;
                    push(4'(i), ACT_INVALID, failures[i], 1'b0);
                  end
                end
                ST_VALID: begin
                  // a valid session without keepalive just keeps its negative lifetime
                  if (renews[i]) begin
                    status[i] = ST_RENEWING;
                    time_left[i] = int'(retry_reg);
                    failures[i] = 4'd0;
                    push(4'(i), ACT_RENEW, 4'd0, 1'b0);
                  end
                end
                default: begin
                  in_use[i] = 1'b0;
                  push(4'(i), ACT_REMOVED, 4'd0, 1'b0);
                end
              endcase
            end
          end
        end
        push(4'd0, ACT_DONE, 4'd0, 1'b1);
      end
      REQ_CREATE: begin
        placed = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !in_use[i]) begin
            placed = 1'b1;
            in_use[i] = 1'b1;
            status[i] = ST_WAITING;
            time_left[i] = int'(lifetime_reg);
            failures[i] = 4'd0;
            retries_allowed[i] = r.retry_limit;
            renews[i] = r.keep_alive;
            push(4'(i), ACT_CREATED, 4'd0, 1'b1);
          end
        end
        if (!placed) push(4'd0, ACT_FULL, 4'd0, 1'b1);
      end
      REQ_ADVERT: begin
        if (in_use[r.slot]) begin
          status[r.slot] = ST_VALID;
          time_left[r.slot] = int'(lifetime_reg);
          failures[r.slot] = 4'd0;
          push(r.slot, ACT_VALID, 4'd0, 1'b1);
        end else begin
          push(r.slot, ACT_UNUSED, 4'd0, 1'b1);
        end
      end
      default: push(4'd0, ACT_DONE, 4'd0, 1'b1);
    endcase
  endfunction

  function void flag(string field, logic [3:0] want, logic [3:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endfunction

  function void check_result(result_t got);
    result_t want;
    results_seen++;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, slot %0d action %0d fail_count %0d last %0b",
               $time, got.session_slot, got.action, got.fail_count, got.last);
      return;
    end
    want = awaited.pop_front();
    action_count[want.action]++;
    if (got.session_slot !== want.session_slot)
      flag("session_slot", want.session_slot, got.session_slot);
    if (got.action !== want.action) flag("action", want.action, got.action);
    if (got.fail_count !== want.fail_count) flag("fail_count", want.fail_count, got.fail_count);
    if (got.last !== want.last) flag("last", 4'(want.last), 4'(got.last));
  endfunction
endclass

module proxy_session_retry_table_core_tb;

  // long enough for a full-table tick, so this covers any request in flight
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_REQUESTS = 82;
  // request kind the block answers with a plain done result, leaving the table alone
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 result_valid;
  result_t              result;

  session_table_tracker table_model = new();
  bit                   idle_off = 1'b0;
  int                   quiet_cycles = 0;

  proxy_session_retry_table_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .result_valid(result_valid),
    .result      (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // results cannot be held off, so every strobe is checked as it comes
  always @(posedge clk) begin
    if (!rst && result_valid) table_model.check_result(result);
  end

  // watchdog: counts cycles where neither a request nor a result moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("proxy_session_retry_table_core_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request and hold it until the block takes it; a random gap
  // beforehand lands on whatever stage the previous request has reached
  task automatic issue(input req_t item);
    if (!idle_off && $urandom_range(0, 99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 6)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    table_model.note_request(item);
  endtask

  // every field random, so the ones a request kind ignores still toggle
  function automatic req_t noisy_request(logic [1:0] kind);
    logic [31:0] bits;
    req_t        r;
    bits = $urandom;
    r = bits[$bits(req_t)-1:0];
    r.req_type = kind;
    return r;
  endfunction

  task automatic tick(input logic [15:0] elapsed);
    req_t r;
    r = noisy_request(REQ_TICK);
    r.elapsed = elapsed;
    issue(r);
  endtask

  task automatic create(input logic keep, input logic [3:0] limit);
    req_t r;
    r = noisy_request(REQ_CREATE);
    r.keep_alive = keep;
    r.retry_limit = limit;
    issue(r);
  endtask

  task automatic advert(input logic [3:0] slot);
    req_t r;
    r = noisy_request(REQ_ADVERT);
    r.slot = slot;
    issue(r);
  endtask

  // wait for the last awaited result, then for any tail of work in the block
  task automatic drain();
    start <= 1'b0;
    while (table_model.awaited_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] lifetime, input logic [CFG_W-1:0] retry);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VALID_LIFETIME;
    cfg_data  <= lifetime;
    @(posedge clk);
    table_model.write_register(CFG_VALID_LIFETIME, lifetime);
    cfg_index <= CFG_RETRY_TIMEOUT;
    cfg_data  <= retry;
    @(posedge clk);
    table_model.write_register(CFG_RETRY_TIMEOUT, retry);
    cfg_we <= 1'b0;
  endtask

  // elapsed times scaled to the current timeouts so sessions actually expire,
  // with zero, the maximum and full-range values mixed in
  function automatic logic [15:0] pick_elapsed();
    int roll;
    int span;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'd0;
    if (roll < 20) return 16'hFFFF;
    if (roll < 35) return 16'($urandom);
    if (roll < 50) span = int'(table_model.lifetime_reg) * 3 / 2 + 2;
    else span = int'(table_model.retry_reg) * 2 + 2;
    if (span > 65535) span = 65535;
    return 16'($urandom_range(0, span));
  endfunction

  // mostly live sessions, now and then a free one
  function automatic logic [3:0] pick_advert_slot();
    int base;
    int s;
    base = $urandom_range(0, 15);
    if ($urandom_range(0, 3) != 0) begin
      for (int i = 0; i < 16; i++) begin
        s = (base + i) % 16;
        if (table_model.in_use[s]) return 4'(s);
      end
    end
    return 4'(base);
  endfunction

  task automatic random_traffic(input int count);
    int sent;
    int roll;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        // burst of creates, enough to fill the table and get refused
        repeat (17) create(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        sent += 17;
      end else begin
        if (roll < 45) tick(pick_elapsed());
        else if (roll < 65) create(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        else if (roll < 95) advert(pick_advert_slot());
        else issue(noisy_request(REQ_RESERVED));
        sent++;
      end
    end
  endtask

  initial begin
    table_model.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, with the reset values of both registers
    tick(16'd0);                      // empty table
    issue(noisy_request(REQ_RESERVED));
    advert(4'd15);                    // free slot
    create(1'b0, 4'd0);
    create(1'b1, 4'd15);
    create(1'b1, 4'd1);
    advert(4'd1);
    tick(16'd30000);                  // lifetimes reach exactly zero
    tick(16'd1);                      // invalid, renewing and retry together
    tick(16'hFFFF);                   // removal, retry, retries exhausted
    tick(16'hFFFF);
    create(1'b0, 4'd3);
    advert(4'd0);                     // valid without keepalive
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'hFFFF);                   // lifetime clamps at the floor
    tick(16'hFFFF);
    advert(4'd0);                     // reload after saturation
    drain();

    apply_settings(16'd0, 16'd0);
    random_traffic(PHASE_REQUESTS);
    drain();

    apply_settings(16'hFFFF, 16'hFFFF);
    random_traffic(PHASE_REQUESTS);
    drain();

    // back-to-back stretch with no sender gaps at all
    apply_settings(16'd1000, 16'd200);
    idle_off = 1'b1;
    random_traffic(PHASE_REQUESTS);
    idle_off = 1'b0;
    drain();

    apply_settings(16'($urandom_range(0, 4000)), 16'($urandom_range(0, 1500)));
    random_traffic(PHASE_REQUESTS);
    drain();

    apply_settings(16'd300, 16'd5000);
    random_traffic(PHASE_REQUESTS);
    drain();

    $display("covered %0d requests, %0d results; %0d retries, %0d invalid, %0d renewals",
             table_model.requests_seen, table_model.results_seen,
             table_model.action_count[ACT_RETRY], table_model.action_count[ACT_INVALID],
             table_model.action_count[ACT_RENEW]);
    $display("%0d removals, %0d created, %0d refused as full, %0d adverts, %0d clamped",
             table_model.action_count[ACT_REMOVED], table_model.action_count[ACT_CREATED],
             table_model.action_count[ACT_FULL], table_model.action_count[ACT_VALID],
             table_model.saturations);
    if (table_model.errors == 0) begin
      $display("proxy_session_retry_table_core_tb: PASS");
    end else begin
      $display("proxy_session_retry_table_core_tb: FAIL");
    end
    $finish;
  end

endmodule
